[rtl/core/mre_pkg.sv]
// Shared types and constants for the 4x4 matrix row engine.
`timescale 1ns / 1ps

package mre_pkg;

   // Port widths fixed by the interface.
   localparam int FIELD_W = 32;
   localparam int ROW_W   = 2;
   localparam int NUM_COL = 4;
   localparam int NUM_ENT = NUM_COL * NUM_COL;

   // Default number format: signed Q16.16.
   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   typedef enum logic [1:0] {
      FUNC_LOAD = 2'd0,
      FUNC_MUL  = 2'd1,
      FUNC_ADD  = 2'd2,
      FUNC_SUB  = 2'd3
   } func_type;

   // Control that travels with each beat down the pipeline.
   typedef struct packed {
      logic             valid;
      func_type         func;
      logic [ROW_W-1:0] row;
   } tag_type;

endpackage

[rtl/core/mre_bank.sv]
// Resident right-hand matrix B, written one row per load beat.
`timescale 1ns / 1ps

module mre_bank #(
   parameter int ELEM_WIDTH = mre_pkg::ELEM_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [mre_pkg::ROW_W-1:0]            wr_row,
   input  logic signed [ELEM_WIDTH-1:0]         wr_data [mre_pkg::NUM_COL],
   output logic signed [ELEM_WIDTH-1:0]         b_mat   [mre_pkg::NUM_ENT]
);

   logic signed [ELEM_WIDTH-1:0] b_mat_ff [mre_pkg::NUM_ENT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mre_pkg::NUM_ENT; i++) begin
            b_mat_ff[i] <= '0;
         end
      end else if (wr_en) begin
         for (int j = 0; j < mre_pkg::NUM_COL; j++) begin
            b_mat_ff[{wr_row, 2'(j)}] <= wr_data[j];
         end
      end
   end

   assign b_mat = b_mat_ff;

endmodule

[rtl/core/mre_mac_stage.sv]
// First arithmetic stage: sixteen products for multiply, element sums or differences.
`timescale 1ns / 1ps

module mre_mac_stage #(
   parameter int ELEM_WIDTH = mre_pkg::ELEM_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  mre_pkg::tag_type                    tag_in,
   input  logic signed [ELEM_WIDTH-1:0]        a_elem  [mre_pkg::NUM_COL],
   input  logic signed [ELEM_WIDTH-1:0]        b_mat   [mre_pkg::NUM_ENT],
   output mre_pkg::tag_type                    tag_ff,
   output logic signed [2*ELEM_WIDTH-1:0]      prod_ff [mre_pkg::NUM_COL][mre_pkg::NUM_COL],
   output logic signed [ELEM_WIDTH:0]          lin_ff  [mre_pkg::NUM_COL]
);

   localparam int PROD_W = 2 * ELEM_WIDTH;
   localparam int LIN_W  = ELEM_WIDTH + 1;

   logic signed [PROD_W-1:0] prod_in [mre_pkg::NUM_COL][mre_pkg::NUM_COL];
   logic signed [LIN_W-1:0]  lin_in  [mre_pkg::NUM_COL];

   // Column j of the product row needs a[k] * B[k][j] for every k.
   always_comb begin
      for (int j = 0; j < mre_pkg::NUM_COL; j++) begin
         for (int k = 0; k < mre_pkg::NUM_COL; k++) begin
            prod_in[j][k] = PROD_W'(a_elem[k]) * PROD_W'(b_mat[{2'(k), 2'(j)}]);
         end
         if (tag_in.func == mre_pkg::FUNC_SUB) begin
            lin_in[j] = LIN_W'(a_elem[j]) - LIN_W'(b_mat[{tag_in.row, 2'(j)}]);
         end else begin
            lin_in[j] = LIN_W'(a_elem[j]) + LIN_W'(b_mat[{tag_in.row, 2'(j)}]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (adv) begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         lin_ff  <= lin_in;
      end
   end

endmodule

[rtl/core/mre_reduce.sv]
// Second stage: dot-product sum, fixed-point shift, saturation and the result register.
`timescale 1ns / 1ps

module mre_reduce #(
   parameter int ELEM_WIDTH = mre_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = mre_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  mre_pkg::tag_type                     tag,
   input  logic signed [2*ELEM_WIDTH-1:0]       prod [mre_pkg::NUM_COL][mre_pkg::NUM_COL],
   input  logic signed [ELEM_WIDTH:0]           lin  [mre_pkg::NUM_COL],
   output logic                                 out_valid_ff,
   output logic [mre_pkg::ROW_W-1:0]            out_row_ff,
   output logic [mre_pkg::FIELD_W-1:0]          res_ff [mre_pkg::NUM_COL]
);

   localparam int SUM_W = 2 * ELEM_WIDTH + 2;
   localparam int LIN_W = ELEM_WIDTH + 1;
   localparam logic signed [SUM_W-1:0] SUM_MAX =
      SUM_W'((64'sd1 <<< (ELEM_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);
   localparam logic signed [LIN_W-1:0] LIN_MAX = LIN_W'(SUM_MAX);
   localparam logic signed [LIN_W-1:0] LIN_MIN = LIN_W'(SUM_MIN);

   logic signed [ELEM_WIDTH-1:0]    res_elem [mre_pkg::NUM_COL];
   logic [mre_pkg::FIELD_W-1:0]     res_in   [mre_pkg::NUM_COL];

   for (genvar j = 0; j < mre_pkg::NUM_COL; j++) begin : g_col
      logic signed [SUM_W-1:0] sum;
      logic signed [SUM_W-1:0] shifted;

      always_comb begin
         sum = '0;
         for (int k = 0; k < mre_pkg::NUM_COL; k++) begin
            sum = sum + SUM_W'(prod[j][k]);
         end
         // Arithmetic shift rounds toward minus infinity.
         shifted = sum >>> FRAC_BITS;

         if (tag.func == mre_pkg::FUNC_MUL) begin
            if (shifted > SUM_MAX) begin
               res_elem[j] = ELEM_WIDTH'(SUM_MAX);
            end else if (shifted < SUM_MIN) begin
               res_elem[j] = ELEM_WIDTH'(SUM_MIN);
            end else begin
               res_elem[j] = shifted[ELEM_WIDTH-1:0];
            end
         end else begin
            if (lin[j] > LIN_MAX) begin
               res_elem[j] = ELEM_WIDTH'(LIN_MAX);
            end else if (lin[j] < LIN_MIN) begin
               res_elem[j] = ELEM_WIDTH'(LIN_MIN);
            end else begin
               res_elem[j] = lin[j][ELEM_WIDTH-1:0];
            end
         end
         res_in[j] = mre_pkg::FIELD_W'(res_elem[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_row_ff <= tag.row;
         res_ff     <= res_in;
      end
   end

endmodule

[rtl/core/matrix4_row_engine.sv]
// Top level of the 4x4 matrix row engine: input register, B bank and two arithmetic stages.
`timescale 1ns / 1ps

// The engine holds a 4x4 right-hand matrix B and streams rows of a left matrix A through it.
// Each request beat carries an operation, a row number and four signed fixed-point elements.
// A load beat writes that row of B and produces no response. Multiply, add and subtract beats
// each produce one response beat with the same row of A*B, A+B or A-B, saturated to the
// element width and sign-extended to 32 bits on the response ports.
// The pipeline has three registers: the request register, the product register and the
// response register. Each response passes through all three in that order, and a new request
// can be accepted in every cycle while req_stall is low. Each stage advances independently,
// so empty slots are filled even while rsp_stall is high; req_stall rises only when the
// request and product registers hold arithmetic beats and the response beat is stalled.
// A load takes effect as it leaves the request register, so the very next beat sees the
// new row of B. Loads never occupy a response slot.
// Reset is synchronous and clears B to zero and all stage valid bits; there is no clear pass.
// While rsp_stall is high the response beat holds its value until it is taken.

module matrix4_row_engine #(
   parameter int FRAC_BITS  = mre_pkg::FRAC_BITS_DEF,
   parameter int ELEM_WIDTH = mre_pkg::ELEM_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_func,
   input  logic [mre_pkg::ROW_W-1:0]        req_row_index,
   input  logic [mre_pkg::FIELD_W-1:0]      req_elem_0,
   input  logic [mre_pkg::FIELD_W-1:0]      req_elem_1,
   input  logic [mre_pkg::FIELD_W-1:0]      req_elem_2,
   input  logic [mre_pkg::FIELD_W-1:0]      req_elem_3,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mre_pkg::ROW_W-1:0]        rsp_out_row,
   output logic [mre_pkg::FIELD_W-1:0]      rsp_res_0,
   output logic [mre_pkg::FIELD_W-1:0]      rsp_res_1,
   output logic [mre_pkg::FIELD_W-1:0]      rsp_res_2,
   output logic [mre_pkg::FIELD_W-1:0]      rsp_res_3
);

   mre_pkg::tag_type              s1_tag_ff;
   mre_pkg::tag_type              s1_tag_in;
   logic signed [ELEM_WIDTH-1:0]  s1_elem_ff [mre_pkg::NUM_COL];
   logic signed [ELEM_WIDTH-1:0]  s1_elem_in [mre_pkg::NUM_COL];

   mre_pkg::tag_type              mac_tag;
   mre_pkg::tag_type              s2_tag;
   logic signed [2*ELEM_WIDTH-1:0] s2_prod [mre_pkg::NUM_COL][mre_pkg::NUM_COL];
   logic signed [ELEM_WIDTH:0]    s2_lin  [mre_pkg::NUM_COL];
   logic signed [ELEM_WIDTH-1:0]  b_mat   [mre_pkg::NUM_ENT];
   logic [mre_pkg::FIELD_W-1:0]   res     [mre_pkg::NUM_COL];

   logic s1_is_load;
   logic out_adv;
   logic s2_adv;
   logic s1_adv;
   logic b_wr_en;

   // Stage advance chain: a stage may load when it is empty or its contents move on.
   // A load beat leaves the request register without needing a downstream slot.
   assign s1_is_load = s1_tag_ff.valid && (s1_tag_ff.func == mre_pkg::FUNC_LOAD);
   assign out_adv    = !rsp_valid || !rsp_stall;
   assign s2_adv     = !s2_tag.valid || out_adv;
   assign s1_adv     = !s1_tag_ff.valid || s1_is_load || s2_adv;
   assign req_stall  = !s1_adv;
   assign b_wr_en    = s1_is_load;

   // Only the low ELEM_WIDTH bits of each element are significant.
   always_comb begin
      s1_tag_in       = s1_tag_ff;
      s1_elem_in      = s1_elem_ff;
      if (s1_adv) begin
         s1_tag_in.valid = req_valid;
         s1_tag_in.func  = mre_pkg::func_type'(req_func);
         s1_tag_in.row   = req_row_index;
         s1_elem_in[0]   = req_elem_0[ELEM_WIDTH-1:0];
         s1_elem_in[1]   = req_elem_1[ELEM_WIDTH-1:0];
         s1_elem_in[2]   = req_elem_2[ELEM_WIDTH-1:0];
         s1_elem_in[3]   = req_elem_3[ELEM_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
      end else begin
         s1_tag_ff <= s1_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_elem_ff <= s1_elem_in;
   end

   // Load beats drop out here; only arithmetic beats enter the product stage.
   always_comb begin
      mac_tag       = s1_tag_ff;
      mac_tag.valid = s1_tag_ff.valid && !s1_is_load;
   end

   mre_bank #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_bank (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (b_wr_en),
      .wr_row  (s1_tag_ff.row),
      .wr_data (s1_elem_ff),
      .b_mat   (b_mat)
   );

   mre_mac_stage #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .adv     (s2_adv),
      .tag_in  (mac_tag),
      .a_elem  (s1_elem_ff),
      .b_mat   (b_mat),
      .tag_ff  (s2_tag),
      .prod_ff (s2_prod),
      .lin_ff  (s2_lin)
   );

   mre_reduce #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_reduce (
      .clock        (clock),
      .reset        (reset),
      .adv          (out_adv),
      .tag          (s2_tag),
      .prod         (s2_prod),
      .lin          (s2_lin),
      .out_valid_ff (rsp_valid),
      .out_row_ff   (rsp_out_row),
      .res_ff       (res)
   );

   assign rsp_res_0 = res[0];
   assign rsp_res_1 = res[1];
   assign rsp_res_2 = res[2];
   assign rsp_res_3 = res[3];

   // A load beat leaving the request register must not create a product-stage beat.
   assert property (@(posedge clock) disable iff (reset)
      s1_is_load && s2_adv |=> !s2_tag.valid)
      else $error("load beat entered the product stage");

   // The request side stalls only behind an arithmetic beat that cannot move on.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_tag_ff.valid && !s1_is_load && s2_tag.valid && rsp_valid)
      else $error("request stalled with room in the pipeline");

   // With every stage full and the response stalled, the request side must stall.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && s2_tag.valid && s1_tag_ff.valid && !s1_is_load
      |-> req_stall)
      else $error("request accepted into a full pipeline");

endmodule

[sim/tb_matrix4_row_engine.sv]
// Self-checking testbench for the 4x4 matrix row engine: directed table, then random traffic.
`timescale 1ns / 1ps

// The bench drives request beats at the falling edge and samples both handshakes at the
// rising edge. Every accepted request beat is run through a local model of the engine,
// which keeps its own copy of the resident B matrix. Beats that produce a response push the
// expected row onto a FIFO, and each accepted response beat is checked field by field
// against the oldest entry. The directed table comes first. Rows whose answer is obvious
// carry that answer typed in, and every other row is checked against the model. The random
// traffic then runs in three idling phases: a rarely idle sender with a busy receiver, the
// reverse, and finally full throughput on both sides.

module tb_matrix4_row_engine;

   // Number format used by both the DUT instance and the local model.
   localparam int FRAC = mre_pkg::FRAC_BITS_DEF;
   localparam int EW   = mre_pkg::ELEM_WIDTH_DEF;

   // Hard stop, far beyond what a correct run needs even with heavy stalling.
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_BEATS = 317;

   logic clock;
   logic reset;

   logic                            req_valid;
   logic                            req_stall;
   logic [1:0]                      req_func;
   logic [mre_pkg::ROW_W-1:0]       req_row_index;
   logic [mre_pkg::FIELD_W-1:0]     req_elem_0;
   logic [mre_pkg::FIELD_W-1:0]     req_elem_1;
   logic [mre_pkg::FIELD_W-1:0]     req_elem_2;
   logic [mre_pkg::FIELD_W-1:0]     req_elem_3;

   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [mre_pkg::ROW_W-1:0]       rsp_out_row;
   logic [mre_pkg::FIELD_W-1:0]     rsp_res_0;
   logic [mre_pkg::FIELD_W-1:0]     rsp_res_1;
   logic [mre_pkg::FIELD_W-1:0]     rsp_res_2;
   logic [mre_pkg::FIELD_W-1:0]     rsp_res_3;

   // One expected response beat.
   typedef struct packed {
      logic [1:0]        row;
      logic [0:3][31:0]  res;
   } row_result_type;

   // One line of the directed table. When typed is set, want is the expected response row.
   typedef struct packed {
      mre_pkg::func_type op;
      logic [1:0]        row;
      logic [0:3][31:0]  a;
      logic              typed;
      logic [0:3][31:0]  want;
   } dir_beat_type;

   localparam logic [31:0] ONE = 32'h0001_0000;

   localparam dir_beat_type DIRECTED_BEATS [25] = '{
      // Right after reset B is all zero: products vanish, sums and differences return A.
      '{mre_pkg::FUNC_MUL, 2'd3, {32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFFFFFF},
        1'b1, {4{32'h0}}},
      '{mre_pkg::FUNC_ADD, 2'd1, {32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'h12345678},
        1'b1, {32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'h12345678}},
      '{mre_pkg::FUNC_SUB, 2'd2, {32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h00000000},
        1'b1, {32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h00000000}},
      // Extreme B row, then sums and differences that clip at both rails.
      '{mre_pkg::FUNC_LOAD, 2'd0, {32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000},
        1'b0, {4{32'h0}}},
      '{mre_pkg::FUNC_ADD, 2'd0, {32'h00000001, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000001},
        1'b1, {32'h7FFFFFFF, 32'h7FFFFFFE, 32'h80000000, 32'h80000001}},
      '{mre_pkg::FUNC_SUB, 2'd0, {32'h80000000, 32'h00000000, 32'h7FFFFFFF, 32'h00000000},
        1'b1, {32'h80000000, 32'h80000001, 32'h7FFFFFFF, 32'h7FFFFFFF}},
      // Identity matrix: a product row must return A unchanged, extremes included.
      '{mre_pkg::FUNC_LOAD, 2'd0, {ONE, 32'h0, 32'h0, 32'h0}, 1'b0, {4{32'h0}}},
      '{mre_pkg::FUNC_LOAD, 2'd1, {32'h0, ONE, 32'h0, 32'h0}, 1'b0, {4{32'h0}}},
      '{mre_pkg::FUNC_LOAD, 2'd2, {32'h0, 32'h0, ONE, 32'h0}, 1'b0, {4{32'h0}}},
      '{mre_pkg::FUNC_LOAD, 2'd3, {32'h0, 32'h0, 32'h0, ONE}, 1'b0, {4{32'h0}}},
      '{mre_pkg::FUNC_MUL, 2'd2, {32'h12345678, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF},
        1'b1, {32'h12345678, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF}},
      // A load followed at once by a product that depends on it; 2^30 * 2.0 just overflows.
      '{mre_pkg::FUNC_LOAD, 2'd1, {32'h0, 32'h0002_0000, 32'h0, 32'h0},
        1'b0, {4{32'h0}}},
      '{mre_pkg::FUNC_MUL, 2'd1, {32'h0, 32'h40000000, 32'h0, 32'h0},
        1'b1, {32'h0, 32'h7FFFFFFF, 32'h0, 32'h0}},
      // -2^30 * 2.0 lands exactly on the negative rail; one step lower clips to it.
      '{mre_pkg::FUNC_MUL, 2'd0, {32'h0, 32'hC0000000, 32'h0, 32'h0},
        1'b1, {32'h0, 32'h80000000, 32'h0, 32'h0}},
      '{mre_pkg::FUNC_MUL, 2'd3, {32'h0, 32'hBFFFFFFF, 32'h0, 32'h0},
        1'b1, {32'h0, 32'h80000000, 32'h0, 32'h0}},
      // Tiny products: the shift rounds toward minus infinity, so -1 stays -1 and +1 drops.
      '{mre_pkg::FUNC_LOAD, 2'd3, {32'h00000001, 32'h0, 32'h0, 32'h0},
        1'b0, {4{32'h0}}},
      '{mre_pkg::FUNC_MUL, 2'd2, {32'h0, 32'h0, 32'h0, 32'hFFFFFFFF},
        1'b1, {32'hFFFFFFFF, 32'h0, 32'h0, 32'h0}},
      '{mre_pkg::FUNC_MUL, 2'd1, {32'h0, 32'h0, 32'h0, 32'h00000001},
        1'b1, {4{32'h0}}},
      '{mre_pkg::FUNC_ADD, 2'd3, {32'h7FFFFFFF, 32'h12345678, 32'h80000000, 32'hFFFF0000},
        1'b0, {4{32'h0}}},
      // Every entry of B at the negative rail: the dot products overflow 64 bits.
      '{mre_pkg::FUNC_LOAD, 2'd0, {4{32'h80000000}}, 1'b0, {4{32'h0}}},
      '{mre_pkg::FUNC_LOAD, 2'd1, {4{32'h80000000}}, 1'b0, {4{32'h0}}},
      '{mre_pkg::FUNC_LOAD, 2'd2, {4{32'h80000000}}, 1'b0, {4{32'h0}}},
      '{mre_pkg::FUNC_LOAD, 2'd3, {4{32'h80000000}}, 1'b0, {4{32'h0}}},
      '{mre_pkg::FUNC_MUL, 2'd0, {4{32'h80000000}}, 1'b1, {4{32'h7FFFFFFF}}},
      '{mre_pkg::FUNC_MUL, 2'd3, {4{32'h7FFFFFFF}}, 1'b1, {4{32'h80000000}}}
   };

   // Local copy of the resident matrix, indexed [row][column], as signed values.
   longint         b_store [4][4];
   row_result_type pending_rows [$];

   int failures    = 0;
   int beats_sent  = 0;
   int cycle_count = 0;
   int idle_pct    = 0;
   int stall_pct   = 0;

   matrix4_row_engine #(
      .FRAC_BITS  (FRAC),
      .ELEM_WIDTH (EW)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_row_index (req_row_index),
      .req_elem_0    (req_elem_0),
      .req_elem_1    (req_elem_1),
      .req_elem_2    (req_elem_2),
      .req_elem_3    (req_elem_3),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_row   (rsp_out_row),
      .rsp_res_0     (rsp_res_0),
      .rsp_res_1     (rsp_res_1),
      .rsp_res_2     (rsp_res_2),
      .rsp_res_3     (rsp_res_3)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // An element is the sign extension of its low EW bits; higher input bits are ignored.
   function automatic longint elem_value(input logic [31:0] raw);
      logic [63:0] t;
      t = {32'd0, raw} << (64 - EW);
      return $signed(t) >>> (64 - EW);
   endfunction

   // Clip to the EW-bit range; the low 32 bits of an in-range value are already sign-extended.
   function automatic logic [31:0] clamp_elem(input logic signed [127:0] v);
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      hi_lim = (128'sd1 <<< (EW - 1)) - 128'sd1;
      lo_lim = -(128'sd1 <<< (EW - 1));
      if (v > hi_lim) return hi_lim[31:0];
      if (v < lo_lim) return lo_lim[31:0];
      return v[31:0];
   endfunction

   // Applies one request beat to the local matrix copy. Returns 1 when the beat yields a row.
   function automatic bit engine_step(input mre_pkg::func_type op, input logic [1:0] row,
                                      input logic [0:3][31:0] a,
                                      output logic [0:3][31:0] res);
      longint              av [4];
      logic signed [127:0] acc;
      logic signed [127:0] x;
      logic signed [127:0] y;
      res = '0;
      for (int k = 0; k < 4; k++) av[k] = elem_value(a[k]);
      if (op == mre_pkg::FUNC_LOAD) begin
         for (int k = 0; k < 4; k++) b_store[row][k] = av[k];
         return 1'b0;
      end
      for (int j = 0; j < 4; j++) begin
         case (op)
            mre_pkg::FUNC_MUL: begin
               // Exact sum of the four products, then an arithmetic shift.
               acc = '0;
               for (int k = 0; k < 4; k++) begin
                  x = av[k];
                  y = b_store[k][j];
                  acc = acc + x * y;
               end
               res[j] = clamp_elem(acc >>> FRAC);
            end
            mre_pkg::FUNC_ADD: begin
               x = av[j];
               y = b_store[row][j];
               res[j] = clamp_elem(x + y);
            end
            default: begin
               x = av[j];
               y = b_store[row][j];
               res[j] = clamp_elem(x - y);
            end
         endcase
      end
      return 1'b1;
   endfunction

   // Mix of rail values, small and medium Q16.16 numbers, and fully random words.
   function automatic logic [31:0] rand_elem();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(9))
         0:       return 32'h7FFFFFFF;
         1:       return 32'h80000000;
         2:       return 32'h00000000;
         3, 4, 5: return {{12{r[19]}}, r[19:0]};
         6:       return {{4{r[27]}}, r[27:0]};
         default: return r;
      endcase
   endfunction

   // Called at a falling edge. Idles at random, presents the beat, and holds it until it is
   // taken. The expected row comes from the model unless the caller typed one in.
   task automatic send_beat(input mre_pkg::func_type op, input logic [1:0] row,
                            input logic [0:3][31:0] a, input bit typed,
                            input logic [0:3][31:0] want);
      logic [0:3][31:0] res;
      row_result_type   exp_row;
      while ($urandom_range(99) < idle_pct) begin
         // The payload is junk while valid is low; the engine must not look at it.
         req_valid     = 1'b0;
         req_func      = 2'($urandom);
         req_row_index = 2'($urandom);
         req_elem_0    = $urandom;
         req_elem_1    = $urandom;
         req_elem_2    = $urandom;
         req_elem_3    = $urandom;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_func      = op;
      req_row_index = row;
      req_elem_0    = a[0];
      req_elem_1    = a[1];
      req_elem_2    = a[2];
      req_elem_3    = a[3];
      do @(posedge clock); while (req_stall);
      if (engine_step(op, row, a, res)) begin
         exp_row.row = row;
         exp_row.res = typed ? want : res;
         pending_rows.push_back(exp_row);
      end
      beats_sent++;
      @(negedge clock);
   endtask

   // Holds the request side quiet until every expected row has come back.
   task automatic drain();
      req_valid = 1'b0;
      while (pending_rows.size() != 0) @(negedge clock);
   endtask

   // A beat with an arbitrary operation, row and elements.
   task automatic send_random();
      logic [0:3][31:0] a;
      for (int j = 0; j < 4; j++) a[j] = rand_elem();
      send_beat(mre_pkg::func_type'($urandom_range(3)), 2'($urandom_range(3)), a, 1'b0, '0);
   endtask

   // A well-formed pass: load a whole new B, then stream four rows of A through it.
   task automatic send_matrix_pass();
      logic [0:3][31:0]  a;
      mre_pkg::func_type op;
      for (int r = 0; r < 4; r++) begin
         for (int j = 0; j < 4; j++) a[j] = rand_elem();
         send_beat(mre_pkg::FUNC_LOAD, 2'(r), a, 1'b0, '0);
      end
      for (int r = 0; r < 4; r++) begin
         for (int j = 0; j < 4; j++) a[j] = rand_elem();
         op = ($urandom_range(2) == 0) ? mre_pkg::func_type'($urandom_range(2, 3))
                                       : mre_pkg::FUNC_MUL;
         send_beat(op, 2'($urandom_range(3)), a, 1'b0, '0);
      end
   endtask

   // The receiver stalls at random; the rate is set by the stimulus phase.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   // Response checker: every beat taken must match the oldest pending row, field by field.
   always @(posedge clock) begin : rsp_check
      row_result_type   want;
      logic [0:3][31:0] got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_res_0, rsp_res_1, rsp_res_2, rsp_res_3};
         if (pending_rows.size() == 0) begin
            $display("%0t: response beat with nothing pending: row %0d, res %h %h %h %h",
                     $time, rsp_out_row, got[0], got[1], got[2], got[3]);
            failures++;
         end else begin
            want = pending_rows.pop_front();
            if (rsp_out_row !== want.row) begin
               $display("%0t: out_row expected %0d, actual %0d", $time, want.row, rsp_out_row);
               failures++;
            end
            for (int j = 0; j < 4; j++) begin
               if (got[j] !== want.res[j]) begin
                  $display("%0t: res_%0d of row %0d expected %h, actual %h",
                           $time, j, want.row, want.res[j], got[j]);
                  failures++;
               end
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** matrix4_row_engine: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      int goal;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = mre_pkg::FUNC_LOAD;
      req_row_index = '0;
      req_elem_0    = '0;
      req_elem_1    = '0;
      req_elem_2    = '0;
      req_elem_3    = '0;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++) b_store[r][c] = 0;

      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed table, with the first idling mix already in force.
      idle_pct  = 8;
      stall_pct = 57;
      foreach (DIRECTED_BEATS[i])
         send_beat(DIRECTED_BEATS[i].op, DIRECTED_BEATS[i].row, DIRECTED_BEATS[i].a,
                   DIRECTED_BEATS[i].typed, DIRECTED_BEATS[i].want);
      // The engine must come back to empty with no new requests arriving.
      drain();

      // Random traffic in three phases: busy receiver, idle sender, then full throughput.
      for (int p = 0; p < 3; p++) begin
         idle_pct  = (p == 0) ? 8 : (p == 1) ? 57 : 0;
         stall_pct = (p == 0) ? 57 : (p == 1) ? 8 : 0;
         goal = beats_sent + PHASE_BEATS;
         while (beats_sent < goal) begin
            if ($urandom_range(9) < 3) send_matrix_pass();
            else send_random();
         end
         drain();
      end

      // Let any stray response beat surface before the verdict.
      repeat (8) @(posedge clock);
      if (failures == 0 && pending_rows.size() == 0) begin
         $display("** matrix4_row_engine: PASSED **");
      end else begin
         $display("** matrix4_row_engine: FAILED **");
      end
      $finish;
   end

endmodule
